[design/pesm_pkg.sv]
// Shared constants and handshake types for the priority event state machine.
package pesm_pkg;

  // Default table sizes.
  localparam int MAX_STATES_DEF = 16;
  localparam int MAX_EDGES_DEF  = 32;

  // Fixed field widths.
  localparam int CMD_W    = 3;
  localparam int KIND_W   = 4;
  localparam int IDX_IN_W = 8;
  localparam int EV_W     = 8;
  localparam int PRIO_W   = 8;
  localparam int TICK_W   = 16;
  localparam int STATUS_W = 3;
  localparam int ID_W     = 5;
  localparam int TIME_W   = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD_STATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INIT      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EVENT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TIME      = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIRE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADIDX = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOINIT = 3'd4;

  // State kind of the initial pseudo-state.
  localparam logic [KIND_W-1:0] KIND_INITIAL = 4'd3;

  // Request to the transition table scanner.
  typedef struct packed {
    logic go;
    logic init_mode;
  } scan_req_t;

  // Answer from the transition table scanner.
  typedef struct packed {
    logic done;
    logic found;
  } scan_rsp_t;

endpackage

[design/pesm_edge_scan.sv]
// Transition table memory with a one-entry-per-cycle matching scanner.
module pesm_edge_scan
  import pesm_pkg::*;
#(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int MAX_EDGES  = MAX_EDGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [$clog2(MAX_EDGES)-1:0]      wr_idx,
  input  logic [$clog2(MAX_STATES)-1:0]     wr_src,
  input  logic [$clog2(MAX_STATES)-1:0]     wr_tgt,
  input  logic                              wr_trig,
  input  logic [EV_W-1:0]                   wr_ev,
  input  logic signed [PRIO_W-1:0]          wr_prio,
  input  logic [$clog2(MAX_EDGES+1)-1:0]    edge_total,
  input  scan_req_t                         req,
  input  logic [$clog2(MAX_STATES)-1:0]     key,
  input  logic [EV_W-1:0]                   ev,
  output scan_rsp_t                         rsp,
  output logic [$clog2(MAX_STATES)-1:0]     target
);

  localparam int SW  = $clog2(MAX_STATES);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);

  typedef struct packed {
    logic [SW-1:0]             src;
    logic [SW-1:0]             tgt;
    logic                      trig;
    logic [EV_W-1:0]           ev;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  entry_t mem [MAX_EDGES];
  entry_t rd;

  logic                      scanning;
  logic                      init_mode;
  logic [ECW-1:0]            ptr;
  logic                      pend;
  logic                      found;
  logic signed [PRIO_W-1:0]  best;
  logic [SW-1:0]             key_q;
  logic [EV_W-1:0]           ev_q;

  logic                      src_hit;
  logic                      ev_ok;
  logic                      init_hit;
  logic                      ev_hit;
  logic                      hit;
  logic                      finish;
  logic                      found_next;
  logic [SW-1:0]             target_next;
  logic signed [PRIO_W-1:0]  best_next;

  // Table memory: one write port for adds, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= '{src: wr_src, tgt: wr_tgt, trig: wr_trig, ev: wr_ev, prio: wr_prio};
    end
    rd <= mem[ptr[EW-1:0]];
  end

  // Match test on the entry that came back from memory this cycle.
  always_comb begin
    src_hit     = (rd.src == key_q);
    ev_ok       = !rd.trig || (rd.ev == ev_q);
    init_hit    = pend && src_hit;
    ev_hit      = pend && src_hit && ev_ok && ($signed(rd.prio) > best);
    hit         = init_mode ? init_hit : ev_hit;
    finish      = (init_mode && init_hit) || (ptr >= edge_total);
    found_next  = found || hit;
    target_next = hit ? rd.tgt : target;
    best_next   = ev_hit ? rd.prio : best;
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      pend     <= 1'b0;
      rsp      <= '0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go) begin
        scanning <= 1'b1;
        pend     <= 1'b0;
      end else if (scanning) begin
        if (finish) begin
          scanning  <= 1'b0;
          pend      <= 1'b0;
          rsp.done  <= 1'b1;
          rsp.found <= found_next;
        end else begin
          pend <= 1'b1;
        end
      end
    end
  end

  // Scan pointer, running best and captured search keys.
  always_ff @(posedge clk) begin
    if (req.go) begin
      init_mode <= req.init_mode;
      ptr       <= '0;
      found     <= 1'b0;
      best      <= -PRIO_W'(1);
      key_q     <= key;
      ev_q      <= ev;
    end else if (scanning) begin
      found  <= found_next;
      best   <= best_next;
      target <= target_next;
      if (!finish) begin
        ptr <= ptr + ECW'(1);
      end
    end
  end

endmodule

[design/priority_event_state_machine.sv]
// Top level of the programmable priority event state machine.
//
// A user writes states and transitions with commands, initializes, then sends
// events and time steps; every accepted item gives exactly one result, shown
// for one cycle with done high, and the receiver cannot stall it. An item is
// taken when start is high and busy is low. Add state, add transition, an
// unused command code and any command refused as not initialized give their
// result in the cycle after acceptance and never raise busy. A time step
// reads, then does a saturating add and write back of the current state's
// dwell counter in the state memory. An event runs the transition scan, which
// reads one table entry per cycle through the single read port of the
// transition memory. Initialize scans the state memory one entry per cycle up
// to the first top-level initial state and then scans the transition table for
// its first outgoing transition.
module priority_event_state_machine
  import pesm_pkg::*;
#(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int MAX_EDGES  = MAX_EDGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [KIND_W-1:0]          state_kind,
  input  logic                       parent_is_none,
  input  logic [IDX_IN_W-1:0]        from_state,
  input  logic [IDX_IN_W-1:0]        to_state,
  input  logic                       has_trigger,
  input  logic [EV_W-1:0]            event_id,
  input  logic signed [PRIO_W-1:0]   priority_req,
  input  logic [TICK_W-1:0]          tick_amount,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [ID_W-1:0]            result_id,
  output logic [TIME_W-1:0]          time_value
);

  localparam int SW  = $clog2(MAX_STATES);
  localparam int SCW = $clog2(MAX_STATES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int CW  = (SCW > IDX_IN_W) ? SCW : IDX_IN_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STATE_SCAN,
    S_EDGE_WAIT,
    S_DWELL_WR
  } fsm_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              top;
    logic [TIME_W-1:0] dwell;
  } sentry_t;

  fsm_t fsm;

  logic [SCW-1:0]    state_total;
  logic [ECW-1:0]    edge_total;
  logic              current_valid;
  logic [SW-1:0]     current_index;
  logic              is_init;
  logic [SCW-1:0]    sptr;
  logic              spend;
  logic [SW-1:0]     spend_idx;
  logic [TICK_W-1:0] ticks_q;

  sentry_t smem [MAX_STATES];
  sentry_t s_rdata;
  sentry_t s_wdata;
  logic [SW-1:0] s_raddr;
  logic [SW-1:0] s_waddr;
  logic          s_we;

  logic          accept;
  logic          st_full;
  logic          e_full;
  logic          bad_idx;
  logic          add_state_ok;
  logic          add_edge_ok;
  logic          s_hit;
  logic [TIME_W:0]   sum_wide;
  logic [TIME_W-1:0] dwell_sum;

  scan_req_t     scan_req;
  scan_rsp_t     scan_rsp;
  logic [SW-1:0] scan_key;
  logic [SW-1:0] scan_target;

  assign busy   = (fsm != S_IDLE);
  assign accept = start && !busy;

  // Command checks on the incoming item.
  always_comb begin
    st_full      = (state_total >= SCW'(MAX_STATES));
    e_full       = (edge_total >= ECW'(MAX_EDGES));
    bad_idx      = (CW'(from_state) >= CW'(state_total)) ||
                   (CW'(to_state) >= CW'(state_total));
    add_state_ok = accept && (cmd == CMD_ADD_STATE) && !st_full;
    add_edge_ok  = accept && (cmd == CMD_ADD_EDGE) && !bad_idx && !e_full;
  end

  // Saturating dwell update on the entry read back from the state memory.
  always_comb begin
    sum_wide  = {1'b0, s_rdata.dwell} + (TIME_W+1)'(ticks_q);
    dwell_sum = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
  end

  // State memory ports: add state or dwell write back, scan or current-state read.
  always_comb begin
    s_raddr = (fsm == S_STATE_SCAN) ? sptr[SW-1:0] : current_index;
    s_we    = add_state_ok || (fsm == S_DWELL_WR);
    s_waddr = add_state_ok ? state_total[SW-1:0] : current_index;
    if (add_state_ok) begin
      s_wdata = '{kind: state_kind, top: parent_is_none, dwell: '0};
    end else begin
      s_wdata = '{kind: s_rdata.kind, top: s_rdata.top, dwell: dwell_sum};
    end
    s_hit = spend && (s_rdata.kind == KIND_INITIAL) && s_rdata.top;
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[s_raddr];
  end

  // Scan requests: an event from idle, or the initial state found during init.
  always_comb begin
    scan_req.go        = (accept && (cmd == CMD_EVENT) && current_valid) ||
                         ((fsm == S_STATE_SCAN) && s_hit);
    scan_req.init_mode = (fsm == S_STATE_SCAN);
    scan_key           = (fsm == S_STATE_SCAN) ? spend_idx : current_index;
  end

  pesm_edge_scan #(
    .MAX_STATES (MAX_STATES),
    .MAX_EDGES  (MAX_EDGES)
  ) u_edge_scan (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (add_edge_ok),
    .wr_idx     (edge_total[EW-1:0]),
    .wr_src     (from_state[SW-1:0]),
    .wr_tgt     (to_state[SW-1:0]),
    .wr_trig    (has_trigger),
    .wr_ev      (event_id),
    .wr_prio    (priority_req),
    .edge_total (edge_total),
    .req        (scan_req),
    .key        (scan_key),
    .ev         (event_id),
    .rsp        (scan_rsp),
    .target     (scan_target)
  );

  // Command sequencer with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= S_IDLE;
      done          <= 1'b0;
      state_total   <= '0;
      edge_total    <= '0;
      current_valid <= 1'b0;
      current_index <= '0;
      spend         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (fsm)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_ADD_STATE: begin
                done       <= 1'b1;
                time_value <= '0;
                if (st_full) begin
                  status    <= ST_FULL;
                  result_id <= '0;
                end else begin
                  status      <= ST_OK;
                  result_id   <= ID_W'(state_total);
                  state_total <= state_total + SCW'(1);
                end
              end
              CMD_ADD_EDGE: begin
                done       <= 1'b1;
                time_value <= '0;
                if (bad_idx) begin
                  status    <= ST_BADIDX;
                  result_id <= '0;
                end else if (e_full) begin
                  status    <= ST_FULL;
                  result_id <= '0;
                end else begin
                  status     <= ST_OK;
                  result_id  <= ID_W'(edge_total);
                  edge_total <= edge_total + ECW'(1);
                end
              end
              CMD_INIT: begin
                if (state_total == '0) begin
                  done       <= 1'b1;
                  status     <= ST_NOINIT;
                  result_id  <= '0;
                  time_value <= '0;
                end else begin
                  fsm   <= S_STATE_SCAN;
                  sptr  <= '0;
                  spend <= 1'b0;
                end
              end
              CMD_EVENT: begin
                if (!current_valid) begin
                  done       <= 1'b1;
                  status     <= ST_NOINIT;
                  result_id  <= '0;
                  time_value <= '0;
                end else begin
                  fsm     <= S_EDGE_WAIT;
                  is_init <= 1'b0;
                end
              end
              CMD_TIME: begin
                if (!current_valid) begin
                  done       <= 1'b1;
                  status     <= ST_NOINIT;
                  result_id  <= '0;
                  time_value <= '0;
                end else begin
                  fsm     <= S_DWELL_WR;
                  ticks_q <= tick_amount;
                end
              end
              default: begin
                done       <= 1'b1;
                status     <= ST_BADIDX;
                result_id  <= '0;
                time_value <= '0;
              end
            endcase
          end
        end

        // Walk the state memory for the first top-level initial state.
        S_STATE_SCAN: begin
          if (s_hit) begin
            fsm     <= S_EDGE_WAIT;
            is_init <= 1'b1;
            spend   <= 1'b0;
          end else if (sptr >= state_total) begin
            fsm           <= S_IDLE;
            spend         <= 1'b0;
            current_index <= '0;
            current_valid <= 1'b1;
            done          <= 1'b1;
            status        <= ST_OK;
            result_id     <= '0;
            time_value    <= '0;
          end else begin
            sptr      <= sptr + SCW'(1);
            spend     <= 1'b1;
            spend_idx <= sptr[SW-1:0];
          end
        end

        // Take the answer of the transition scan.
        S_EDGE_WAIT: begin
          if (scan_rsp.done) begin
            fsm        <= S_IDLE;
            done       <= 1'b1;
            time_value <= '0;
            if (is_init) begin
              current_valid <= 1'b1;
              current_index <= scan_rsp.found ? scan_target : '0;
              status        <= ST_OK;
              result_id     <= scan_rsp.found ? ID_W'(scan_target) : '0;
            end else if (scan_rsp.found) begin
              current_index <= scan_target;
              status        <= ST_OK;
              result_id     <= ID_W'(scan_target);
            end else begin
              status    <= ST_NOFIRE;
              result_id <= ID_W'(current_index);
            end
          end
        end

        // Dwell counter write back; the memory write happens this cycle.
        S_DWELL_WR: begin
          fsm        <= S_IDLE;
          done       <= 1'b1;
          status     <= ST_OK;
          result_id  <= ID_W'(current_index);
          time_value <= dwell_sum;
        end

        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  // A result only appears once the sequencer is back to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // The state count never passes the table size.
  assert property (@(posedge clk) disable iff (rst) state_total <= SCW'(MAX_STATES))
    else $error("state count beyond table size");

  // The current state always names a state that has been added.
  assert property (@(posedge clk) disable iff (rst)
      current_valid |-> (SCW'(current_index) < state_total))
    else $error("current state outside state table");

  // Table adds answer in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
      (accept && ((cmd == CMD_ADD_STATE) || (cmd == CMD_ADD_EDGE))) |=> done)
    else $error("add command without result in next cycle");

  // A failed result never reports a dwell value.
  assert property (@(posedge clk) disable iff (rst)
      (done && (status != ST_OK)) |-> (time_value == '0))
    else $error("dwell value on a failed result");

endmodule

[test/tb_priority_event_state_machine.sv]
// Self-checking testbench for the programmable priority event state machine.
`timescale 1ns / 100ps

module tb_priority_event_state_machine
  import pesm_pkg::*;
();

  // Command codes that the block does not define.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_TIME + 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = '1;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [CMD_W-1:0]         cmd;
    logic [KIND_W-1:0]        kind;
    logic                     top;
    logic [IDX_IN_W-1:0]      src;
    logic [IDX_IN_W-1:0]      dst;
    logic                     trig;
    logic [EV_W-1:0]          ev;
    logic signed [PRIO_W-1:0] prio;
    logic [TICK_W-1:0]        ticks;
    bit                       drain;
  } fsm_cmd_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   dwell;
  } fsm_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  fsm_cmd_t cmd_on_bus = '{default: '0};
  logic busy;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0] result_id;
  logic [TIME_W-1:0] time_value;

  fsm_cmd_t cmd_backlog[$];
  fsm_result_t expected_results[$];
  int cmds_taken = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int stall_cycles = 0;
  bit hold_next = 1'b0;

  // Shadow copy of the state and transition tables.
  logic [KIND_W-1:0]        kind_mem [MAX_STATES_DEF];
  logic                     top_mem  [MAX_STATES_DEF];
  logic [TIME_W-1:0]        dwell_mem[MAX_STATES_DEF];
  logic [IDX_IN_W-1:0]      edge_src [MAX_EDGES_DEF];
  logic [IDX_IN_W-1:0]      edge_dst [MAX_EDGES_DEF];
  logic                     edge_trig[MAX_EDGES_DEF];
  logic [EV_W-1:0]          edge_ev  [MAX_EDGES_DEF];
  logic signed [PRIO_W-1:0] edge_prio[MAX_EDGES_DEF];
  int state_cnt = 0;
  int edge_cnt = 0;
  bit cur_valid = 1'b0;
  int cur_state = 0;

  priority_event_state_machine i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd_on_bus.cmd),
    .state_kind    (cmd_on_bus.kind),
    .parent_is_none(cmd_on_bus.top),
    .from_state    (cmd_on_bus.src),
    .to_state      (cmd_on_bus.dst),
    .has_trigger   (cmd_on_bus.trig),
    .event_id      (cmd_on_bus.ev),
    .priority_req  (cmd_on_bus.prio),
    .tick_amount   (cmd_on_bus.ticks),
    .done          (done),
    .status        (status),
    .result_id     (result_id),
    .time_value    (time_value)
  );

  always #4 clk = ~clk;

  // Applies one command to the shadow tables and returns the result it gives.
  function automatic fsm_result_t machine_step(fsm_cmd_t it);
    fsm_result_t r;
    int s;
    int e;
    int p;
    int best;
    int top_prio;
    int pick;
    bit located;
    bit hit;
    logic [TIME_W:0] sum;
    r.status = ST_OK;
    r.id = '0;
    r.dwell = '0;
    case (it.cmd)
      CMD_ADD_STATE: begin
        if (state_cnt >= MAX_STATES_DEF) begin
          r.status = ST_FULL;
        end else begin
          kind_mem[state_cnt] = it.kind;
          top_mem[state_cnt] = it.top;
          dwell_mem[state_cnt] = '0;
          r.id = ID_W'(state_cnt);
          state_cnt++;
        end
      end
      CMD_ADD_EDGE: begin
        // Index check comes before the fullness check.
        if (it.src >= state_cnt || it.dst >= state_cnt) begin
          r.status = ST_BADIDX;
        end else if (edge_cnt >= MAX_EDGES_DEF) begin
          r.status = ST_FULL;
        end else begin
          edge_src[edge_cnt] = it.src;
          edge_dst[edge_cnt] = it.dst;
          edge_trig[edge_cnt] = it.trig;
          edge_ev[edge_cnt] = it.ev;
          edge_prio[edge_cnt] = it.prio;
          r.id = ID_W'(edge_cnt);
          edge_cnt++;
        end
      end
      CMD_INIT: begin
        if (state_cnt == 0) begin
          r.status = ST_NOINIT;
        end else begin
          // First top-level initial state, then its first outgoing transition.
          pick = 0;
          located = 1'b0;
          hit = 1'b0;
          for (s = 0; s < state_cnt; s++) begin
            if (!located && kind_mem[s] == KIND_INITIAL && top_mem[s]) begin
              located = 1'b1;
              for (e = 0; e < edge_cnt; e++) begin
                if (!hit && edge_src[e] == s) begin
                  hit = 1'b1;
                  pick = edge_dst[e];
                end
              end
            end
          end
          cur_state = pick;
          cur_valid = 1'b1;
          r.id = ID_W'(pick);
        end
      end
      CMD_EVENT: begin
        if (!cur_valid) begin
          r.status = ST_NOINIT;
        end else begin
          // Strictly greater keeps the earliest entry on a tie; negatives never win.
          best = -1;
          top_prio = -1;
          for (e = 0; e < edge_cnt; e++) begin
            p = edge_prio[e];
            if (edge_src[e] == cur_state && (!edge_trig[e] || edge_ev[e] == it.ev) &&
                p > top_prio) begin
              top_prio = p;
              best = e;
            end
          end
          if (best < 0) begin
            r.status = ST_NOFIRE;
          end else begin
            cur_state = edge_dst[best];
          end
          r.id = ID_W'(cur_state);
        end
      end
      CMD_TIME: begin
        if (!cur_valid) begin
          r.status = ST_NOINIT;
        end else begin
          // The dwell counter saturates instead of wrapping.
          sum = {1'b0, dwell_mem[cur_state]} + it.ticks;
          dwell_mem[cur_state] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          r.id = ID_W'(cur_state);
          r.dwell = dwell_mem[cur_state];
        end
      end
      default: r.status = ST_BADIDX;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Random filler in every field, so that unused fields toggle too.
  function automatic fsm_cmd_t noise_item(logic [CMD_W-1:0] c);
    fsm_cmd_t it;
    it.cmd = c;
    it.kind = KIND_W'($urandom);
    it.top = 1'($urandom);
    it.src = IDX_IN_W'($urandom);
    it.dst = IDX_IN_W'($urandom);
    it.trig = 1'($urandom);
    it.ev = EV_W'($urandom);
    it.prio = PRIO_W'($urandom);
    it.ticks = TICK_W'($urandom);
    it.drain = 1'b0;
    return it;
  endfunction

  task automatic push_item(fsm_cmd_t it);
    it.drain = hold_next;
    hold_next = 1'b0;
    cmd_backlog.push_back(it);
  endtask

  task automatic add_state(input logic [KIND_W-1:0] k, input logic t);
    fsm_cmd_t it;
    it = noise_item(CMD_ADD_STATE);
    it.kind = k;
    it.top = t;
    push_item(it);
  endtask

  task automatic add_edge(input logic [IDX_IN_W-1:0] s, input logic [IDX_IN_W-1:0] d,
                          input logic t, input logic [EV_W-1:0] ev,
                          input logic signed [PRIO_W-1:0] p);
    fsm_cmd_t it;
    it = noise_item(CMD_ADD_EDGE);
    it.src = s;
    it.dst = d;
    it.trig = t;
    it.ev = ev;
    it.prio = p;
    push_item(it);
  endtask

  task automatic fire(input logic [EV_W-1:0] ev);
    fsm_cmd_t it;
    it = noise_item(CMD_EVENT);
    it.ev = ev;
    push_item(it);
  endtask

  task automatic tick(input logic [TICK_W-1:0] n);
    fsm_cmd_t it;
    it = noise_item(CMD_TIME);
    it.ticks = n;
    push_item(it);
  endtask

  // A small pool of event ids, so that triggers and events meet often.
  function automatic logic [EV_W-1:0] pick_event();
    case ($urandom_range(4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      3: return 8'hA5;
      default: return EV_W'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_IN_W-1:0] pick_index();
    return ($urandom_range(9) == 0) ? IDX_IN_W'($urandom) : IDX_IN_W'($urandom_range(15));
  endfunction

  // Mostly small priorities so that ties occur; sometimes any value.
  function automatic logic signed [PRIO_W-1:0] pick_prio();
    return ($urandom_range(3) == 0) ? PRIO_W'($urandom) : PRIO_W'($urandom_range(3));
  endfunction

  task automatic random_add_state();
    add_state(($urandom_range(2) == 0) ? KIND_INITIAL : KIND_W'($urandom), 1'($urandom));
  endtask

  task automatic random_add_edge();
    add_edge(pick_index(), pick_index(), 1'($urandom), pick_event(), pick_prio());
  endtask

  // Driver: offers the next item once the current one is taken.
  always @(posedge clk) begin
    logic taken;
    int open_cnt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      open_cnt = cmds_taken - results_seen + int'(taken);
      if (taken) begin
        expected_results.push_back(machine_step(cmd_on_bus));
        cmds_taken <= cmds_taken + 1;
      end
      if (start && !taken) begin
        // Hold the item until the block takes it.
      end else if (cmd_backlog.size() != 0 && !(cmd_backlog[0].drain && open_cnt != 0) &&
                   !((cmds_taken < 600 || cmds_taken > 900) && $urandom_range(99) < 8)) begin
        cmd_on_bus <= cmd_backlog.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    fsm_result_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        flag_mismatch("result with no item outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (result_id !== want.id)
          flag_mismatch($sformatf("result_id got %0d want %0d", result_id, want.id));
        if (time_value !== want.dwell)
          flag_mismatch($sformatf("time_value got %0d want %0d", time_value, want.dwell));
      end
    end
  end

  // Watchdog on cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("priority_event_state_machine verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int n;
    int r;
    // Commands before any table exists or before initialize.
    fire(8'h00);
    tick(16'hFFFF);
    push_item(noise_item(CMD_INIT));
    push_item(noise_item(CMD_SPARE_FIRST));
    push_item(noise_item(CMD_SPARE_LAST));
    add_edge(8'd0, 8'd0, 1'b0, 8'h00, 8'sd0);
    // Small table: a nested initial state and a top-level one.
    add_state(4'd0, 1'b1);
    add_state(KIND_INITIAL, 1'b0);
    add_state(KIND_INITIAL, 1'b1);
    add_state(4'hF, 1'b1);
    add_edge(8'd2, 8'hFF, 1'b1, 8'h00, 8'sd1);
    add_edge(8'hFF, 8'd0, 1'b1, 8'h00, 8'sd1);
    // Top-level initial state without outgoing transitions starts at state 0.
    push_item(noise_item(CMD_INIT));
    add_edge(8'd1, 8'd3, 1'b0, 8'h33, -8'sd128);
    add_edge(8'd2, 8'd1, 1'b1, 8'hFF, 8'sd127);
    push_item(noise_item(CMD_INIT));
    // Only a negative priority leaves state 1: nothing fires.
    fire(8'h00);
    add_edge(8'd1, 8'd0, 1'b1, 8'hFF, 8'sd5);
    add_edge(8'd1, 8'd2, 1'b0, 8'h00, 8'sd5);
    // Equal priorities: the earlier entry wins.
    fire(8'hFF);
    tick(16'hFFFF);
    tick(16'h0000);
    fire(8'h12);
    // Repeated initialize keeps dwell counters.
    push_item(noise_item(CMD_INIT));
    fire(8'h00);
    tick(16'h0001);

    // Build the rest of the tables, with commands mixed in.
    hold_next = 1'b1;
    for (n = 0; n < 60; n++) begin
      r = $urandom_range(99);
      if (r < 40) random_add_state();
      else if (r < 85) random_add_edge();
      else if (r < 90) push_item(noise_item(CMD_INIT));
      else if (r < 95) fire(pick_event());
      else tick(TICK_W'($urandom));
    end

    // Mixed traffic over the full tables.
    for (n = 0; n < 1560; n++) begin
      if (n % 150 == 0) hold_next = 1'b1;
      r = $urandom_range(99);
      if (r < 45) fire(pick_event());
      else if (r < 60) tick(($urandom_range(3) == 0) ? 16'hFFFF : TICK_W'($urandom));
      else if (r < 70) push_item(noise_item(CMD_INIT));
      else if (r < 77) random_add_state();
      else if (r < 90) random_add_edge();
      else if (r < 95) push_item(noise_item(CMD_W'($urandom_range(CMD_SPARE_LAST,
                                                                   CMD_SPARE_FIRST))));
      else fire(EV_W'($urandom));
    end

    // A run of large time steps on the start state.
    hold_next = 1'b1;
    push_item(noise_item(CMD_INIT));
    for (n = 0; n < 20; n++) tick(16'hFFFF);
    tick(TICK_W'($urandom));
    fire(pick_event());
    tick(16'h0001);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog.size() != 0 || start || cmds_taken != results_seen) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_cnt == 0) begin
      $display("priority_event_state_machine verification clean");
    end else begin
      $display("priority_event_state_machine verification failed");
    end
    $finish;
  end

endmodule
